[rtl/i2cmw_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Types and constants shared by the i2c master write sequencer.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

  // command opcodes
  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_WAIT_ACK = 2'd2;
  localparam logic [1:0] OP_STOP     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_BIT_DELAY  = 2'd0;
  localparam logic [1:0] REG_EDGE_DELAY = 2'd1;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd2;

  localparam int CfgWidth = 16;

  localparam logic [CfgWidth-1:0] BIT_DELAY_RST  = 16'd3;
  localparam logic [CfgWidth-1:0] EDGE_DELAY_RST = 16'd5;
  localparam logic [CfgWidth-1:0] POLL_LIMIT_RST = 16'd350;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic cmd_done;
    logic ack_missing;
  } out_item_t;

endpackage

[rtl/i2c_master_bitbang_writer_top.sv]
// ----------------------------------------------------------------------------
// i2c_master_bitbang_writer_top
// I2C master write sequencer: one item per tick unless stalled, drives SCL/SDA through
// start, byte write, acknowledge wait and stop sequences.
// ----------------------------------------------------------------------------
// result: an accepted item's result is in the output register in the cycle after it is taken
// throughput: one item per cycle; the only limit is the output register draining
// each item steps the line state machine once, the result register holds one item
// reset: synchronous active-low; lines idle high and driven, registers to 3, 5, 350
module i2c_master_bitbang_writer_top #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cmw_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cmw_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import i2cmw_pkg::*;

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_S1    = 5'd1;
  localparam logic [4:0] PH_S2    = 5'd2;
  localparam logic [4:0] PH_P1    = 5'd3;
  localparam logic [4:0] PH_P2    = 5'd4;
  localparam logic [4:0] PH_WLOW  = 5'd5;
  localparam logic [4:0] PH_WHIGH = 5'd6;
  localparam logic [4:0] PH_WTAIL = 5'd7;
  localparam logic [4:0] PH_A1    = 5'd8;
  localparam logic [4:0] PH_A2    = 5'd9;
  localparam logic [4:0] PH_APOLL = 5'd10;

  localparam logic [32:0] DelayMax = (33'd1 << DELAY_WIDTH) - 33'd1;

  // zero becomes one tick, too wide saturates to the counter range
  function automatic logic [DELAY_WIDTH-1:0] load_delay(input logic [CfgWidth-1:0] cfg);
    logic [32:0] ext;
    ext = {{(33-CfgWidth){1'b0}}, cfg};
    if (ext == 33'd0) begin
      ext = 33'd1;
    end
    if (ext > DelayMax) begin
      ext = DelayMax;
    end
    return ext[DELAY_WIDTH-1:0];
  endfunction

  logic [CfgWidth-1:0]    bit_delay_r, edge_delay_r, poll_limit_r;
  logic [4:0]             phase_r, phase_nxt;
  logic [3:0]             bit_count_r, bit_count_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [DELAY_WIDTH-1:0] delay_count_r, delay_count_nxt, dly;
  logic [15:0]            poll_count_r, poll_count_nxt, poll_base;
  logic                   scl_r, scl_nxt, sda_r, sda_nxt;
  logic                   drive_r, drive_nxt, err_r, err_nxt;
  logic                   done, do_poll;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  logic                   in_acc;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    shift_nxt       = shift_r;
    delay_count_nxt = delay_count_r;
    poll_count_nxt  = poll_count_r;
    scl_nxt         = scl_r;
    sda_nxt         = sda_r;
    drive_nxt       = drive_r;
    err_nxt         = err_r;
    done            = 1'b0;
    do_poll         = 1'b0;
    poll_base       = poll_count_r;
    dly             = delay_count_r;

    if (phase_r == PH_IDLE) begin
      if (in_data.cmd_valid) begin
        err_nxt = 1'b0;
        case (in_data.opcode)
          OP_START: begin
            drive_nxt       = 1'b1;
            scl_nxt         = 1'b1;
            sda_nxt         = 1'b1;
            delay_count_nxt = load_delay(edge_delay_r);
            phase_nxt       = PH_S1;
          end
          OP_WRITE: begin
            drive_nxt       = 1'b1;
            scl_nxt         = 1'b0;
            bit_count_nxt   = 4'd0;
            sda_nxt         = in_data.tx_byte[7];
            shift_nxt       = {in_data.tx_byte[6:0], 1'b0};
            delay_count_nxt = load_delay(bit_delay_r);
            phase_nxt       = PH_WLOW;
          end
          OP_WAIT_ACK: begin
            drive_nxt       = 1'b0;
            sda_nxt         = 1'b1;
            poll_count_nxt  = 16'd0;
            delay_count_nxt = load_delay(bit_delay_r);
            phase_nxt       = PH_A1;
          end
          default: begin
            drive_nxt       = 1'b1;
            scl_nxt         = 1'b0;
            sda_nxt         = 1'b0;
            delay_count_nxt = load_delay(edge_delay_r);
            phase_nxt       = PH_P1;
          end
        endcase
      end
    end else if (phase_r == PH_APOLL) begin
      do_poll = 1'b1;
    end else begin
      if (delay_count_r != '0) begin
        dly = delay_count_r - {{(DELAY_WIDTH-1){1'b0}}, 1'b1};
      end
      delay_count_nxt = dly;
      if (dly == '0) begin
        case (phase_r)
          PH_S1: begin
            sda_nxt         = 1'b0;
            delay_count_nxt = load_delay(edge_delay_r);
            phase_nxt       = PH_S2;
          end
          PH_S2: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_P1: begin
            scl_nxt         = 1'b1;
            sda_nxt         = 1'b1;
            delay_count_nxt = load_delay(edge_delay_r);
            phase_nxt       = PH_P2;
          end
          PH_P2: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_WLOW: begin
            scl_nxt         = 1'b1;
            delay_count_nxt = load_delay(bit_delay_r);
            phase_nxt       = PH_WHIGH;
          end
          PH_WHIGH: begin
            scl_nxt         = 1'b0;
            delay_count_nxt = load_delay(bit_delay_r);
            phase_nxt       = PH_WTAIL;
          end
          PH_WTAIL: begin
            bit_count_nxt = bit_count_r + 4'd1;
            if (bit_count_nxt >= 4'd8) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              sda_nxt         = shift_r[7];
              shift_nxt       = {shift_r[6:0], 1'b0};
              delay_count_nxt = load_delay(bit_delay_r);
              phase_nxt       = PH_WLOW;
            end
          end
          PH_A1: begin
            scl_nxt         = 1'b1;
            delay_count_nxt = load_delay(bit_delay_r);
            phase_nxt       = PH_A2;
          end
          PH_A2: begin
            // first poll starts from a cleared count
            poll_base      = 16'd0;
            poll_count_nxt = 16'd0;
            do_poll        = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    if (do_poll) begin
      if (!in_data.sda_in) begin
        scl_nxt   = 1'b0;
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end else if (poll_base >= poll_limit_r) begin
        // no acknowledge: flag it and release the bus with a stop
        err_nxt         = 1'b1;
        drive_nxt       = 1'b1;
        scl_nxt         = 1'b0;
        sda_nxt         = 1'b0;
        delay_count_nxt = load_delay(edge_delay_r);
        phase_nxt       = PH_P1;
      end else begin
        poll_count_nxt = poll_base + 16'd1;
        phase_nxt      = PH_APOLL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r   <= BIT_DELAY_RST;
      edge_delay_r  <= EDGE_DELAY_RST;
      poll_limit_r  <= POLL_LIMIT_RST;
      phase_r       <= PH_IDLE;
      bit_count_r   <= 4'd0;
      shift_r       <= 8'd0;
      delay_count_r <= '0;
      poll_count_r  <= 16'd0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      drive_r       <= 1'b1;
      err_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BIT_DELAY:  bit_delay_r  <= cfg_wdata;
          REG_EDGE_DELAY: edge_delay_r <= cfg_wdata;
          REG_POLL_LIMIT: poll_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r       <= phase_nxt;
        bit_count_r   <= bit_count_nxt;
        shift_r       <= shift_nxt;
        delay_count_r <= delay_count_nxt;
        poll_count_r  <= poll_count_nxt;
        scl_r         <= scl_nxt;
        sda_r         <= sda_nxt;
        drive_r       <= drive_nxt;
        err_r         <= err_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.scl_level   <= scl_nxt;
      out_data_r.sda_level   <= sda_nxt;
      out_data_r.sda_drive   <= drive_nxt;
      out_data_r.busy_res    <= (phase_nxt != PH_IDLE);
      out_data_r.cmd_done    <= done;
      out_data_r.ack_missing <= err_nxt;
    end
  end

endmodule

[tb/tb_i2c_master_bitbang_writer_top.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_bitbang_writer_top
// Self-checking bench for the i2c master write sequencer. Every tick item is
// stepped through a line model kept in the bench, and each result is compared
// field by field with the oldest prediction. Directed command sequences run
// first, then random start/write/ack/stop frames under random pacing.
// ----------------------------------------------------------------------------
module tb_i2c_master_bitbang_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmw_pkg::*;

  localparam int DelayWidth = 16;
  localparam logic [31:0] DelayMax = (32'd1 << DelayWidth) - 32'd1;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SettleCycles = 4;
  localparam int RandomTicks = 700;

  typedef enum logic [3:0] {
    LN_IDLE, LN_START_HI, LN_START_LO, LN_STOP_LO, LN_STOP_HI,
    LN_BIT_SET, LN_BIT_HIGH, LN_BIT_TAIL, LN_ACK_REL, LN_ACK_HIGH, LN_ACK_POLL
  } line_ph_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  i2c_master_bitbang_writer_top #(
    .DELAY_WIDTH(DelayWidth)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // line model state
  logic [15:0] bit_ticks  = BIT_DELAY_RST;
  logic [15:0] edge_ticks = EDGE_DELAY_RST;
  logic [15:0] poll_limit = POLL_LIMIT_RST;
  line_ph_e    line_ph    = LN_IDLE;
  logic [3:0]  bits_sent  = '0;
  logic [7:0]  shift_byte = '0;
  logic [31:0] delay_left = '0;
  logic [15:0] poll_cnt   = '0;
  logic        scl_q      = 1'b1;
  logic        sda_q      = 1'b1;
  logic        drive_q    = 1'b1;
  logic        err_q      = 1'b0;

  out_item_t line_q[$];
  int        mismatches = 0;
  int        ticks_sent = 0;

  function automatic logic [31:0] delay_load(logic [15:0] ticks);
    logic [31:0] d;
    d = {16'd0, ticks};
    if (d == 0) d = 1;
    if (d > DelayMax) d = DelayMax;
    return d;
  endfunction

  function automatic void begin_stop();
    drive_q    = 1'b1;
    scl_q      = 1'b0;
    sda_q      = 1'b0;
    delay_left = delay_load(edge_ticks);
    line_ph    = LN_STOP_LO;
  endfunction

  function automatic void shift_out_bit();
    sda_q      = shift_byte[7];
    shift_byte = shift_byte << 1;
    delay_left = delay_load(bit_ticks);
    line_ph    = LN_BIT_SET;
  endfunction

  // one look at the acknowledge, returns 1 when the command ends here
  function automatic logic poll_ack(logic sda);
    if (!sda) begin
      scl_q   = 1'b0;
      line_ph = LN_IDLE;
      return 1'b1;
    end
    if (poll_cnt >= poll_limit) begin
      err_q = 1'b1;
      begin_stop();
    end else begin
      poll_cnt = poll_cnt + 16'd1;
      line_ph  = LN_ACK_POLL;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t step_line(in_item_t it);
    out_item_t res;
    logic      done;
    done = 1'b0;
    if (line_ph == LN_IDLE) begin
      if (it.cmd_valid) begin
        err_q = 1'b0;
        case (it.opcode)
          OP_START: begin
            drive_q    = 1'b1;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            delay_left = delay_load(edge_ticks);
            line_ph    = LN_START_HI;
          end
          OP_WRITE: begin
            drive_q    = 1'b1;
            scl_q      = 1'b0;
            shift_byte = it.tx_byte;
            bits_sent  = '0;
            shift_out_bit();
          end
          OP_WAIT_ACK: begin
            drive_q    = 1'b0;
            sda_q      = 1'b1;
            poll_cnt   = '0;
            delay_left = delay_load(bit_ticks);
            line_ph    = LN_ACK_REL;
          end
          default: begin_stop();
        endcase
      end
    end else if (line_ph == LN_ACK_POLL) begin
      done = poll_ack(it.sda_in);
    end else begin
      if (delay_left != 0) delay_left = delay_left - 1;
      if (delay_left == 0) begin
        case (line_ph)
          LN_START_HI: begin
            sda_q      = 1'b0;
            delay_left = delay_load(edge_ticks);
            line_ph    = LN_START_LO;
          end
          LN_START_LO: begin
            scl_q   = 1'b0;
            line_ph = LN_IDLE;
            done    = 1'b1;
          end
          LN_STOP_LO: begin
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            delay_left = delay_load(edge_ticks);
            line_ph    = LN_STOP_HI;
          end
          LN_STOP_HI: begin
            line_ph = LN_IDLE;
            done    = 1'b1;
          end
          LN_BIT_SET: begin
            scl_q      = 1'b1;
            delay_left = delay_load(bit_ticks);
            line_ph    = LN_BIT_HIGH;
          end
          LN_BIT_HIGH: begin
            scl_q      = 1'b0;
            delay_left = delay_load(bit_ticks);
            line_ph    = LN_BIT_TAIL;
          end
          LN_BIT_TAIL: begin
            bits_sent = bits_sent + 4'd1;
            if (bits_sent >= 4'd8) begin
              line_ph = LN_IDLE;
              done    = 1'b1;
            end else begin
              shift_out_bit();
            end
          end
          LN_ACK_REL: begin
            scl_q      = 1'b1;
            delay_left = delay_load(bit_ticks);
            line_ph    = LN_ACK_HIGH;
          end
          LN_ACK_HIGH: begin
            poll_cnt = '0;
            done     = poll_ack(it.sda_in);
          end
          default: line_ph = LN_IDLE;
        endcase
      end
    end
    res.scl_level   = scl_q;
    res.sda_level   = sda_q;
    res.sda_drive   = drive_q;
    res.busy_res    = (line_ph != LN_IDLE);
    res.cmd_done    = done;
    res.ack_missing = err_q;
    return res;
  endfunction

  // true when the next tick samples sda_in for the acknowledge
  function automatic logic polls_this_tick();
    return line_ph == LN_ACK_POLL || (line_ph == LN_ACK_HIGH && delay_left <= 1);
  endfunction

  function automatic in_item_t random_item(logic valid);
    in_item_t it;
    it.cmd_valid = valid;
    it.opcode    = 2'($urandom_range(0, 3));
    it.tx_byte   = 8'($urandom_range(0, 255));
    it.sda_in    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom_range(3, 8));
    if (r < 6) return 16'd1;
    return 16'd2;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b got %0b", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(in_item_t it);
    int   gap;
    logic stalled;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    line_q.push_back(step_line(it));
    ticks_sent++;
  endtask

  task automatic idle_ticks(int n);
    repeat (n) send_item(random_item(1'b0));
  endtask

  // issue one command from idle and tick the line until it is idle again;
  // high_polls acknowledge samples see sda high, later ones see it low
  task automatic run_cmd(logic [1:0] op, logic [7:0] data_byte, int high_polls, bit noise);
    in_item_t it;
    int       high_left;
    high_left    = high_polls;
    it           = random_item(1'b1);
    it.opcode    = op;
    it.tx_byte   = data_byte;
    send_item(it);
    while (line_ph != LN_IDLE) begin
      // commands while busy must be dropped
      it = random_item(noise && ($urandom_range(0, 3) == 0));
      if (polls_this_tick()) begin
        it.sda_in = (high_left > 0);
        if (high_left > 0) high_left--;
      end
      send_item(it);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BIT_DELAY:  bit_ticks  = val;
      REG_EDGE_DELAY: edge_ticks = val;
      REG_POLL_LIMIT: poll_limit = val;
      default: ;
    endcase
  endtask

  task automatic test_default_regs();
    idle_ticks(2);
    run_cmd(OP_START, 8'h00, 0, 1'b0);
    run_cmd(OP_WRITE, 8'h00, 0, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 0, 1'b0);
    run_cmd(OP_WAIT_ACK, 8'h00, 0, 1'b0);
    run_cmd(OP_STOP, 8'h00, 0, 1'b0);
  endtask

  task automatic test_ignored_commands();
    run_cmd(OP_START, 8'h00, 0, 1'b1);
    run_cmd(OP_WRITE, 8'hA5, 0, 1'b1);
    run_cmd(OP_WAIT_ACK, 8'h00, 2, 1'b1);
    run_cmd(OP_STOP, 8'h00, 0, 1'b1);
  endtask

  task automatic test_zero_delays();
    write_reg(REG_BIT_DELAY, 16'd0);
    write_reg(REG_EDGE_DELAY, 16'd0);
    run_cmd(OP_START, 8'h00, 0, 1'b0);
    run_cmd(OP_WRITE, 8'h5A, 0, 1'b0);
    run_cmd(OP_WAIT_ACK, 8'h00, 1, 1'b0);
    run_cmd(OP_STOP, 8'h00, 0, 1'b0);
  endtask

  task automatic test_ack_timeout();
    write_reg(REG_POLL_LIMIT, 16'd0);
    run_cmd(OP_WAIT_ACK, 8'h00, 1, 1'b0);
    // error flag holds until the next command is taken
    idle_ticks(3);
    run_cmd(OP_START, 8'h00, 0, 1'b0);
    write_reg(REG_POLL_LIMIT, 16'd3);
    run_cmd(OP_WAIT_ACK, 8'h00, 3, 1'b0);
    run_cmd(OP_WAIT_ACK, 8'h00, 4, 1'b1);
    write_reg(REG_UNUSED, 16'hFFFF);
    run_cmd(OP_WAIT_ACK, 8'h00, 3, 1'b0);
    run_cmd(OP_STOP, 8'h00, 0, 1'b0);
  endtask

  task automatic test_long_delays();
    write_reg(REG_EDGE_DELAY, 16'd60);
    run_cmd(OP_STOP, 8'h00, 0, 1'b0);
    write_reg(REG_EDGE_DELAY, 16'd1);
    write_reg(REG_BIT_DELAY, 16'd60);
    run_cmd(OP_WAIT_ACK, 8'h00, 0, 1'b0);
    write_reg(REG_BIT_DELAY, 16'd1);
    write_reg(REG_POLL_LIMIT, 16'd60);
    run_cmd(OP_WAIT_ACK, 8'h00, 60, 1'b0);
  endtask

  task automatic test_random_frames();
    int first;
    int n;
    first = ticks_sent;
    while (ticks_sent - first < RandomTicks) begin
      write_reg(REG_BIT_DELAY, pick_delay());
      write_reg(REG_EDGE_DELAY, pick_delay());
      write_reg(REG_POLL_LIMIT, 16'($urandom_range(0, 6)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 4) == 0) begin
          // stray command outside a frame
          idle_ticks($urandom_range(0, 3));
          run_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, poll_limit + 2), 1'b1);
        end else begin
          run_cmd(OP_START, 8'($urandom_range(0, 255)), 0, 1'($urandom_range(0, 1)));
          n = $urandom_range(1, 3);
          repeat (n) begin
            run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 0, 1'($urandom_range(0, 1)));
            run_cmd(OP_WAIT_ACK, 8'($urandom_range(0, 255)),
                    $urandom_range(0, poll_limit + 2), 1'($urandom_range(0, 1)));
          end
          run_cmd(OP_STOP, 8'($urandom_range(0, 255)), 0, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin : result_check
    out_item_t got;
    out_item_t want;
    logic      took;
    int        hold;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      took = rst_n && out_valid && !out_stall;
      got  = out_data;
      @(posedge clk);
      if (took) begin
        if (line_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got %b", $time, got);
          mismatches++;
        end else begin
          want = line_q.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("sda_drive", want.sda_drive, got.sda_drive);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("cmd_done", want.cmd_done, got.cmd_done);
          check_field("ack_missing", want.ack_missing, got.ack_missing);
        end
        hold = $urandom_range(0, 13);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_BIT_DELAY;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_regs();
    test_ignored_commands();
    test_zero_delays();
    test_ack_timeout();
    test_long_delays();
    test_random_frames();
    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && line_q.size() != 0; i++) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (line_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %b got nothing",
               $time, line_q.size(), line_q[0]);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("i2c_master_bitbang_writer_top test passed");
    end else begin
      $display("i2c_master_bitbang_writer_top test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("i2c_master_bitbang_writer_top test failed");
    $finish;
  end

endmodule

[files.f]
rtl/i2cmw_pkg.sv
rtl/i2c_master_bitbang_writer_top.sv
tb/tb_i2c_master_bitbang_writer_top.sv
